// ===== rtl/core/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the stable rank table
// widths, command codes and the cell-to-cell token carried along the chain
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int MaxEntries = 8192;
   localparam int ValueBits  = 32;
   localparam int NumCells   = 32;
   localparam int IdxW       = 14;
   localparam int RankW      = 14;
   localparam int AddrW      = $clog2(MaxEntries);
   localparam int CellDepth  = MaxEntries / NumCells;
   localparam int CellAddrW  = $clog2(CellDepth);
   localparam int CellSelW   = $clog2(NumCells);

   localparam logic CMD_SET   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] REG_ENTRIES = 2'd0;

   // token passed from one cell to the next each cycle, unless held for a sweep
   typedef struct packed {
      logic                 valid;
      logic                 is_query;
      logic                 fetch;
      logic [AddrW-1:0]     addr;
      logic [ValueBits-1:0] value;
      logic [IdxW-1:0]      key_idx;
      logic [IdxW-1:0]      count;
      logic [RankW-1:0]     acc;
   } token_type;

endpackage

// ===== rtl/core/srt_cell.sv =====
// ----------------------------------------------------------------------------
// srt_cell: one cell of the rank chain
// holds a slice of the value store, writes its slice on a set, and on a query
// counts its in-use entries whose key lies below the queried key
// ----------------------------------------------------------------------------
module srt_cell import srt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CellSelW-1:0]  cell_id,
   input  logic                 clear_en,
   input  logic [CellAddrW-1:0] clear_addr,
   input  token_type            tok_in,
   output token_type            tok_out
);

   logic [ValueBits-1:0] mem [CellDepth];

   // sweep: the token for a query visits every entry of the slice
   logic [CellAddrW:0]   ptr_ff, ptr_in;
   logic                 busy_ff, busy_in;
   token_type            hold_ff, hold_in;
   token_type            tok_ff, tok_in_r;
   logic [RankW-1:0]     acc_ff, acc_in;
   logic                 subst_ff;

   logic [ValueBits-1:0] rd_val_ff;
   logic [IdxW-1:0]      rd_idx_ff;
   logic                 rd_below;

   logic [CellAddrW-1:0] rd_addr;
   logic [IdxW-1:0]      ent_idx;
   logic                 sweep_last;
   logic                 own_slot;
   logic                 wr_hit;
   logic                 fetch_hit;

   assign own_slot  = (tok_in.addr[AddrW-1:CellAddrW] == cell_id);
   assign wr_hit    = tok_in.valid && !tok_in.is_query && own_slot;
   assign fetch_hit = tok_in.valid && tok_in.fetch && own_slot && !busy_ff;

   // an idle cell reads at the passing token's address for the key lookup
   assign rd_addr  = busy_ff ? ptr_ff[CellAddrW-1:0] : tok_in.addr[CellAddrW-1:0];
   assign ent_idx  = IdxW'({cell_id, rd_addr}) + IdxW'(1);
   assign sweep_last = busy_ff && ptr_ff[CellAddrW];

   assign rd_below = (rd_val_ff < hold_ff.value) ||
                     ((rd_val_ff == hold_ff.value) && (rd_idx_ff < hold_ff.key_idx));

   always_ff @(posedge clock) begin
      if (clear_en) begin
         mem[clear_addr] <= '0;
      end else if (wr_hit) begin
         mem[tok_in.addr[CellAddrW-1:0]] <= tok_in.value;
      end
      rd_val_ff <= mem[rd_addr];
   end

   always_comb begin
      ptr_in   = ptr_ff;
      busy_in  = busy_ff;
      hold_in  = hold_ff;
      acc_in   = acc_ff;
      tok_in_r = '0;
      if (busy_ff) begin
         ptr_in = ptr_ff + (CellAddrW+1)'(1);
         // previous cycle's read is compared now
         if (ptr_ff != '0 && rd_idx_ff <= hold_ff.count && rd_idx_ff != hold_ff.key_idx &&
             rd_below) begin
            acc_in = acc_ff + RankW'(1);
         end
         if (sweep_last) begin
            busy_in  = 1'b0;
            tok_in_r = hold_ff;
            tok_in_r.acc = acc_in;
         end
      end else if (tok_in.valid && tok_in.is_query && !tok_in.fetch) begin
         busy_in = 1'b1;
         hold_in = tok_in;
         acc_in  = tok_in.acc;
         ptr_in  = '0;
      end else begin
         tok_in_r = tok_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= ent_idx;
      hold_ff   <= hold_in;
      acc_ff    <= acc_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         ptr_ff   <= '0;
         tok_ff   <= '0;
         subst_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         ptr_ff   <= ptr_in;
         tok_ff   <= tok_in_r;
         subst_ff <= fetch_hit;
      end
   end

   // the owner of the queried index puts its stored value into the lookup token
   always_comb begin
      tok_out = tok_ff;
      if (subst_ff) tok_out.value = rd_val_ff;
   end

endmodule

// ===== rtl/core/stable_rank_table.sv =====
// ----------------------------------------------------------------------------
// stable_rank_table: stable rank table over indexed entries
// top level: request decode, cell chain, result register and control register
// ----------------------------------------------------------------------------
// After reset every cell clears its MaxEntries/NumCells (256) entries of the
// value store, one entry a cycle, and req_ready stays low until the clear is
// done. A set transfer writes the value of one index as its token walks the
// chain one cell a cycle; the next transfer is taken once the token has left
// the last cell. A query transfer returns the rank of an index, one plus the
// number of in-use entries whose (value, index) key lies below its own. Its
// token first walks the chain to pick up the stored value of the index, is
// sent again, and then each cell in turn sweeps its MaxEntries/NumCells
// entries at one a cycle through its store's read port; the rank is
// registered when the token leaves the last cell. A query of an index outside
// 1..active (the entries register clamped to 1..MaxEntries) answers rank 0
// in the next cycle, and such a set is dropped. One item is in the chain at a
// time, and no request is taken while a result waits for rsp_ready.
module stable_rank_table import srt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic [IdxW-1:0]      req_index,
   input  logic [31:0]          req_new_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [RankW-1:0]     rsp_rank,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [1:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   logic [IdxW-1:0] count_ff;
   logic [IdxW-1:0] active;
   logic            busy_ff;
   logic            rsp_valid_ff;
   logic [RankW-1:0] rsp_rank_ff;
   token_type       chain [NumCells+1];
   token_type       head;
   token_type       relaunch_ff, relaunch_in;
   logic            in_range;
   logic [CellAddrW:0] clr_ff;
   logic            clearing;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_ENTRIES) ? 32'(count_ff) : '0;

   always_comb begin
      if (count_ff == '0) active = IdxW'(1);
      else if (count_ff > IdxW'(MaxEntries)) active = IdxW'(MaxEntries);
      else active = count_ff;
   end

   assign clearing  = !clr_ff[CellAddrW];
   assign in_range  = (req_index >= IdxW'(1)) && (req_index <= active);
   assign req_ready = !clearing && !busy_ff && !rsp_valid_ff;

   always_comb begin
      head          = '0;
      head.valid    = req_valid && req_ready && in_range;
      head.is_query = (req_command == CMD_QUERY);
      head.fetch    = (req_command == CMD_QUERY);
      head.addr     = AddrW'(req_index - IdxW'(1));
      head.value    = ValueBits'(req_new_value);
      head.key_idx  = req_index;
      head.count    = active;
      head.acc      = RankW'(1);
   end

   // a lookup token back from the chain is sent again to count
   always_comb begin
      relaunch_in = '0;
      if (chain[NumCells].valid && chain[NumCells].fetch) begin
         relaunch_in       = chain[NumCells];
         relaunch_in.fetch = 1'b0;
      end
   end

   assign chain[0] = relaunch_ff.valid ? relaunch_ff : head;

   for (genvar c = 0; c < NumCells; c++) begin : g_cell
      srt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_id    (CellSelW'(c)),
         .clear_en   (clearing),
         .clear_addr (clr_ff[CellAddrW-1:0]),
         .tok_in     (chain[c]),
         .tok_out    (chain[c+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= IdxW'(MaxEntries);
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         relaunch_ff  <= '0;
         clr_ff       <= '0;
      end else begin
         relaunch_ff <= relaunch_in;
         if (clearing) clr_ff <= clr_ff + (CellAddrW+1)'(1);
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_ENTRIES) begin
            count_ff <= csr_pwdata[IdxW-1:0];
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (req_valid && req_ready) begin
            if (in_range) begin
               busy_ff <= 1'b1;
            end else if (req_command == CMD_QUERY) begin
               rsp_valid_ff <= 1'b1;
               rsp_rank_ff  <= '0;
            end
         end
         if (chain[NumCells].valid && !chain[NumCells].fetch) begin
            busy_ff <= 1'b0;
            if (chain[NumCells].is_query) begin
               rsp_valid_ff <= 1'b1;
               rsp_rank_ff  <= chain[NumCells].acc;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rank  = rsp_rank_ff;

endmodule
